// ===== hdl/link_atom_cap_force_projection_core_assert.svh =====
// Assertion macros for the link atom cap and force projection block.
// Used by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef LINK_ATOM_CAP_FORCE_PROJECTION_CORE_ASSERT_SVH
`define LINK_ATOM_CAP_FORCE_PROJECTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LAPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lapf: check failed");
`define LAPF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("lapf: reset check failed");
`else
`define LAPF_ASSERT(lbl, prop)
`define LAPF_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hdl/lapf_pkg.sv =====
// Types, widths and helpers for the link atom cap and force projection block.
// No dependencies; imported by the top level and the testbench.
`default_nettype none
package lapf_pkg;

    localparam int POS_W     = 32;
    localparam int BOND_W    = 21;
    localparam int MAG_W     = 30;
    localparam int RAD_W     = 62;
    localparam int LEN_W     = 31;
    localparam int CAP_W     = 34;
    localparam int U_W       = 32;
    localparam int PROD_W    = 64;
    localparam int DOT_W     = 66;
    localparam int DP_W      = 36;
    localparam int PU_W      = 68;
    localparam int PERP_W    = 36;
    localparam int PMAG_W    = 35;
    localparam int FMDEN_W   = 34;
    localparam int FM_W      = 58;
    localparam int D1_NW     = 61;
    localparam int D1_QW     = 31;
    localparam int D2_NW     = 57;
    localparam int D2_QW     = 57;
    localparam int UNIT_FRAC = 30;
    localparam int ADDR_W    = 3;

    localparam logic [BOND_W-1:0] BOND_RESET = 21'd114295;
    localparam logic              REG_IDX_BOND = 1'b0;

    typedef enum logic [1:0] {
        FAULT_OK   = 2'd0,
        FAULT_ZERO = 2'd1,
        FAULT_SAT  = 2'd2
    } t_fault;

    typedef logic [2:0][POS_W-1:0] t_vec32;

    typedef struct packed {
        logic [2:0][POS_W:0] r;
        t_vec32              pq;
        t_vec32              fl;
        t_vec32              fq;
    } t_s1;

    // travels through the square root
    typedef struct packed {
        logic                zero;
        logic [1:0]          s;
        logic [2:0][MAG_W-1:0] amag;
        logic [2:0]          aneg;
        t_vec32              pq;
        t_vec32              fl;
        t_vec32              fq;
    } t_sqt;

    // travels through the first divider
    typedef struct packed {
        logic                zero;
        logic [2:0]          aneg;
        logic [FMDEN_W-1:0]  den_fm;
        t_vec32              pq;
        t_vec32              fl;
        t_vec32              fq;
    } t_dvt;

    typedef struct packed {
        logic                   zero;
        logic [2:0][CAP_W-1:0]  cap;
        logic [2:0][U_W-1:0]    u;
        logic [2:0][PROD_W-1:0] prod;
        logic [DOT_W-1:0]       dot;
        logic [DP_W-1:0]        dp;
        logic [2:0][PU_W-1:0]   pu;
        logic [2:0][PERP_W-1:0] perp;
        logic [FMDEN_W-1:0]     den_fm;
        t_vec32                 fl;
        t_vec32                 fq;
    } t_mid;

    // travels through the second divider
    typedef struct packed {
        logic                  zero;
        logic [2:0][CAP_W-1:0] cap;
        logic [2:0]            fmneg;
        t_vec32                fl;
        t_vec32                fq;
    } t_fmt;

    typedef struct packed {
        logic             sat;
        logic [POS_W-1:0] val;
    } t_satres;

    function automatic t_satres f_sat(input logic signed [63:0] v);
        t_satres res;
        if (v > 64'sd2147483647) begin
            res.sat = 1'b1;
            res.val = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res.sat = 1'b1;
            res.val = 32'h8000_0000;
        end else begin
            res.sat = 1'b0;
            res.val = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/link_atom_cap_force_projection_core.sv =====
// Link atom cap placement and chain-rule force split, one link pair per item.
// Throughput one item per cycle while no result item is held by i_stall.
// A stalled output item freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and loads the cap bond length with 114295 (0.109 nm).
// Uses lapf_pkg, lapf_sqrt, lapf_div and the assertion macro header.
`default_nettype none
`include "link_atom_cap_force_projection_core_assert.svh"
module link_atom_cap_force_projection_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lapf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input items
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [31:0]                   i_qm_pos_x,
    input  wire logic [31:0]                   i_qm_pos_y,
    input  wire logic [31:0]                   i_qm_pos_z,
    input  wire logic [31:0]                   i_mm_pos_x,
    input  wire logic [31:0]                   i_mm_pos_y,
    input  wire logic [31:0]                   i_mm_pos_z,
    input  wire logic [31:0]                   i_link_force_x,
    input  wire logic [31:0]                   i_link_force_y,
    input  wire logic [31:0]                   i_link_force_z,
    input  wire logic [31:0]                   i_qm_force_x,
    input  wire logic [31:0]                   i_qm_force_y,
    input  wire logic [31:0]                   i_qm_force_z,
    // result items
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [31:0]                        o_cap_pos_x,
    output logic [31:0]                        o_cap_pos_y,
    output logic [31:0]                        o_cap_pos_z,
    output logic [31:0]                        o_qm_force_out_x,
    output logic [31:0]                        o_qm_force_out_y,
    output logic [31:0]                        o_qm_force_out_z,
    output logic [31:0]                        o_mm_force_out_x,
    output logic [31:0]                        o_mm_force_out_y,
    output logic [31:0]                        o_mm_force_out_z,
    output logic [1:0]                         o_fault
);
    import lapf_pkg::*;

    localparam int SQT_W = $bits(t_sqt);
    localparam int DVT_W = $bits(t_dvt);
    localparam int FMT_W = $bits(t_fmt);

    logic w_adv;

    // ---------------- configuration ----------------
    logic [BOND_W-1:0] r_bond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bond <= BOND_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_BOND)) begin
            r_bond <= pwdata[BOND_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_BOND) ? 32'(r_bond) : '0;

    // ---------------- stage 1: separation ----------------
    logic r_s1_vld;
    t_s1  r_s1;
    t_s1  n_s1;

    always_comb begin
        n_s1.pq = {i_qm_pos_z, i_qm_pos_y, i_qm_pos_x};
        n_s1.fl = {i_link_force_z, i_link_force_y, i_link_force_x};
        n_s1.fq = {i_qm_force_z, i_qm_force_y, i_qm_force_x};
        n_s1.r[0] = {i_mm_pos_x[31], i_mm_pos_x} - {i_qm_pos_x[31], i_qm_pos_x};
        n_s1.r[1] = {i_mm_pos_y[31], i_mm_pos_y} - {i_qm_pos_y[31], i_qm_pos_y};
        n_s1.r[2] = {i_mm_pos_z[31], i_mm_pos_z} - {i_qm_pos_z[31], i_qm_pos_z};
    end

    // ---------------- stage 2: prescale ----------------
    logic              r_s2_vld;
    t_sqt              r_s2;
    t_sqt              n_s2;
    logic [2:0][POS_W:0] w_rmag;
    logic [POS_W:0]    w_mor;

    always_comb begin
        w_mor = '0;
        for (int i = 0; i < 3; i++) begin
            w_rmag[i] = r_s1.r[i][POS_W] ? (POS_W+1)'(-r_s1.r[i]) : r_s1.r[i];
            w_mor     = w_mor | w_rmag[i];
        end
        n_s2.pq   = r_s1.pq;
        n_s2.fl   = r_s1.fl;
        n_s2.fq   = r_s1.fq;
        n_s2.zero = (w_mor == '0);
        // least shift that brings every component below 2^30
        priority if (w_mor[32]) begin
            n_s2.s = 2'd3;
        end else if (w_mor[31]) begin
            n_s2.s = 2'd2;
        end else if (w_mor[30]) begin
            n_s2.s = 2'd1;
        end else begin
            n_s2.s = 2'd0;
        end
        for (int i = 0; i < 3; i++) begin
            n_s2.aneg[i] = r_s1.r[i][POS_W];
            n_s2.amag[i] = MAG_W'(w_rmag[i] >> n_s2.s);
        end
    end

    // ---------------- stages 3, 4: squares and sum ----------------
    logic                    r_s3_vld;
    t_sqt                    r_s3;
    logic [2:0][2*MAG_W-1:0] r_s3_sq;
    logic                    r_s4_vld;
    t_sqt                    r_s4;
    logic [RAD_W-1:0]        r_s4_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= r_s2;
            for (int i = 0; i < 3; i++) begin
                r_s3_sq[i] <= (2*MAG_W)'(r_s2.amag[i]) * (2*MAG_W)'(r_s2.amag[i]);
            end
            r_s4    <= r_s3;
            r_s4_n2 <= RAD_W'(r_s3_sq[0]) + RAD_W'(r_s3_sq[1]) + RAD_W'(r_s3_sq[2]);
        end
    end

    // ---------------- length ----------------
    logic             w_sq_vld;
    logic [LEN_W-1:0] w_len;
    logic [SQT_W-1:0] w_sq_tag;
    t_sqt             w_sqt;

    lapf_sqrt #(
        .NW (RAD_W),
        .TW (SQT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s4_vld),
        .i_rad   (r_s4_n2),
        .i_tag   (r_s4),
        .o_valid (w_sq_vld),
        .o_root  (w_len),
        .o_tag   (w_sq_tag)
    );

    assign w_sqt = t_sqt'(w_sq_tag);

    // ---------------- stage 5: dividends for cap offset and unit vector ----------------
    logic                        r_s5_vld;
    logic [5:0][D1_NW-1:0]       r_s5_num;
    logic [LEN_W-1:0]            r_s5_den;
    t_dvt                        r_s5_tag;
    t_dvt                        n_s5_tag;
    logic [5:0][D1_NW-1:0]       n_s5_num;
    logic [LEN_W-1:0]            w_len_nz;

    // coincident atoms give a zero length; divide by one so the cap stays on Pq
    assign w_len_nz = (w_len == '0) ? LEN_W'(1) : w_len;

    always_comb begin
        n_s5_tag.zero   = w_sqt.zero;
        n_s5_tag.aneg   = w_sqt.aneg;
        n_s5_tag.den_fm = FMDEN_W'(w_len_nz) << w_sqt.s;
        n_s5_tag.pq     = w_sqt.pq;
        n_s5_tag.fl     = w_sqt.fl;
        n_s5_tag.fq     = w_sqt.fq;
        for (int i = 0; i < 3; i++) begin
            n_s5_num[i]     = D1_NW'(r_bond) * D1_NW'(w_sqt.amag[i]) + D1_NW'(w_len_nz >> 1);
            n_s5_num[3 + i] = (D1_NW'(w_sqt.amag[i]) << UNIT_FRAC) + D1_NW'(w_len_nz >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_adv) begin
            r_s5_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_num <= n_s5_num;
            r_s5_den <= w_len_nz;
            r_s5_tag <= n_s5_tag;
        end
    end

    logic                  w_d1_vld;
    logic [5:0][D1_QW-1:0] w_d1_quo;
    logic [DVT_W-1:0]      w_d1_tagv;
    t_dvt                  w_d1_tag;

    lapf_div #(
        .LANES (6),
        .NW    (D1_NW),
        .DW    (LEN_W),
        .QW    (D1_QW),
        .TW    (DVT_W)
    ) u_div_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s5_vld),
        .i_num   (r_s5_num),
        .i_den   (r_s5_den),
        .i_tag   (r_s5_tag),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_tag   (w_d1_tagv)
    );

    assign w_d1_tag = t_dvt'(w_d1_tagv);

    // ---------------- stages 6..11: projection ----------------
    t_mid       r_mid [6];
    t_mid       n_mid [6];
    logic [5:0] r_mid_vld;

    logic [DOT_W-1:0]       w_dmag;
    logic [DOT_W-1:0]       w_drnd;
    logic [2:0][PU_W-1:0]   w_pmag;
    logic [2:0][PU_W-1:0]   w_prnd;
    logic [2:0][PU_W-1:0]   w_psgn;

    // cap position and signed unit vector
    always_comb begin
        n_mid[0]        = '0;
        n_mid[0].zero   = w_d1_tag.zero;
        n_mid[0].den_fm = w_d1_tag.den_fm;
        n_mid[0].fl     = w_d1_tag.fl;
        n_mid[0].fq     = w_d1_tag.fq;
        for (int i = 0; i < 3; i++) begin
            n_mid[0].cap[i] = w_d1_tag.aneg[i]
                ? CAP_W'($signed(w_d1_tag.pq[i])) - CAP_W'(w_d1_quo[i])
                : CAP_W'($signed(w_d1_tag.pq[i])) + CAP_W'(w_d1_quo[i]);
            n_mid[0].u[i] = w_d1_tag.aneg[i] ? -U_W'(w_d1_quo[3 + i]) : U_W'(w_d1_quo[3 + i]);
        end
    end

    // Fl_i * u_i
    always_comb begin
        n_mid[1] = r_mid[0];
        for (int i = 0; i < 3; i++) begin
            n_mid[1].prod[i] = PROD_W'($signed(PROD_W'($signed(r_mid[0].fl[i])))
                                     * $signed(PROD_W'($signed(r_mid[0].u[i]))));
        end
    end

    always_comb begin
        n_mid[2]     = r_mid[1];
        n_mid[2].dot = DOT_W'($signed(r_mid[1].prod[0])) + DOT_W'($signed(r_mid[1].prod[1]))
                     + DOT_W'($signed(r_mid[1].prod[2]));
    end

    // dp = dot / 2^30, rounded half away from zero
    always_comb begin
        n_mid[3] = r_mid[2];
        w_dmag   = r_mid[2].dot[DOT_W-1] ? DOT_W'(-r_mid[2].dot) : r_mid[2].dot;
        w_drnd   = (w_dmag + (DOT_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
        n_mid[3].dp = r_mid[2].dot[DOT_W-1] ? DP_W'(-w_drnd) : DP_W'(w_drnd);
    end

    always_comb begin
        n_mid[4] = r_mid[3];
        for (int i = 0; i < 3; i++) begin
            n_mid[4].pu[i] = PU_W'($signed(PU_W'($signed(r_mid[3].dp)))
                                 * $signed(PU_W'($signed(r_mid[3].u[i]))));
        end
    end

    // perpendicular part of the link force
    always_comb begin
        n_mid[5] = r_mid[4];
        for (int i = 0; i < 3; i++) begin
            w_pmag[i] = r_mid[4].pu[i][PU_W-1] ? PU_W'(-r_mid[4].pu[i]) : r_mid[4].pu[i];
            w_prnd[i] = (w_pmag[i] + (PU_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
            w_psgn[i] = r_mid[4].pu[i][PU_W-1] ? PU_W'(-w_prnd[i]) : w_prnd[i];
            n_mid[5].perp[i] = PERP_W'(PU_W'($signed(r_mid[4].fl[i])) - w_psgn[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= '0;
        end else if (w_adv) begin
            r_mid_vld <= {r_mid_vld[4:0], w_d1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 6; k++) begin
                r_mid[k] <= n_mid[k];
            end
        end
    end

    // ---------------- stage 12: dividend for the classical force ----------------
    logic                    r_s12_vld;
    logic [2:0][D2_NW-1:0]   r_s12_num;
    logic [FMDEN_W-1:0]      r_s12_den;
    t_fmt                    r_s12_tag;
    logic [2:0][D2_NW-1:0]   n_s12_num;
    t_fmt                    n_s12_tag;
    logic [2:0][PMAG_W-1:0]  w_perp_mag;

    always_comb begin
        n_s12_tag.zero = r_mid[5].zero;
        n_s12_tag.cap  = r_mid[5].cap;
        n_s12_tag.fl   = r_mid[5].fl;
        n_s12_tag.fq   = r_mid[5].fq;
        for (int i = 0; i < 3; i++) begin
            n_s12_tag.fmneg[i] = r_mid[5].perp[i][PERP_W-1];
            w_perp_mag[i] = r_mid[5].perp[i][PERP_W-1] ? PMAG_W'(-r_mid[5].perp[i])
                                                        : PMAG_W'(r_mid[5].perp[i]);
            n_s12_num[i] = D2_NW'(r_bond) * D2_NW'(w_perp_mag[i])
                         + D2_NW'(r_mid[5].den_fm >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_vld <= 1'b0;
        end else if (w_adv) begin
            r_s12_vld <= r_mid_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s12_num <= n_s12_num;
            r_s12_den <= r_mid[5].den_fm;
            r_s12_tag <= n_s12_tag;
        end
    end

    logic                  w_d2_vld;
    logic [2:0][D2_QW-1:0] w_d2_quo;
    logic [FMT_W-1:0]      w_d2_tagv;
    t_fmt                  w_d2_tag;

    lapf_div #(
        .LANES (3),
        .NW    (D2_NW),
        .DW    (FMDEN_W),
        .QW    (D2_QW),
        .TW    (FMT_W)
    ) u_div_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s12_vld),
        .i_num   (r_s12_num),
        .i_den   (r_s12_den),
        .i_tag   (r_s12_tag),
        .o_valid (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_tag   (w_d2_tagv)
    );

    assign w_d2_tag = t_fmt'(w_d2_tagv);

    // ---------------- output stage: saturate and report ----------------
    logic                 r_out_vld;
    t_vec32               r_out_cap;
    t_vec32               r_out_qfo;
    t_vec32               r_out_mfo;
    t_fault               r_out_fault;
    t_vec32               n_out_cap;
    t_vec32               n_out_qfo;
    t_vec32               n_out_mfo;
    t_fault               n_out_fault;
    logic [2:0][FM_W-1:0] w_fm;
    t_satres [2:0]        w_cap_sat;
    t_satres [2:0]        w_fm_sat;
    t_satres [2:0]        w_fq_sat;
    logic                 w_any_sat;

    always_comb begin
        w_any_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_fm[i] = w_d2_tag.fmneg[i] ? -FM_W'(w_d2_quo[i]) : FM_W'(w_d2_quo[i]);
            w_cap_sat[i] = f_sat(64'($signed(w_d2_tag.cap[i])));
            w_fm_sat[i]  = f_sat(64'($signed(w_fm[i])));
            w_fq_sat[i]  = f_sat(64'($signed(w_d2_tag.fq[i])) + 64'($signed(w_d2_tag.fl[i]))
                               - 64'($signed(w_fm[i])));
            w_any_sat = w_any_sat | w_cap_sat[i].sat | w_fm_sat[i].sat | w_fq_sat[i].sat;
        end
        if (w_d2_tag.zero) begin
            // coincident atoms: cap stays on the quantum atom, no force is passed on
            for (int i = 0; i < 3; i++) begin
                n_out_cap[i] = w_d2_tag.cap[i][POS_W-1:0];
                n_out_qfo[i] = '0;
                n_out_mfo[i] = '0;
            end
            n_out_fault = FAULT_ZERO;
        end else begin
            for (int i = 0; i < 3; i++) begin
                n_out_cap[i] = w_cap_sat[i].val;
                n_out_qfo[i] = w_fq_sat[i].val;
                n_out_mfo[i] = w_fm_sat[i].val;
            end
            n_out_fault = w_any_sat ? FAULT_SAT : FAULT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_cap   <= n_out_cap;
            r_out_qfo   <= n_out_qfo;
            r_out_mfo   <= n_out_mfo;
            r_out_fault <= n_out_fault;
        end
    end

    // whole pipe moves unless the result item is held
    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;

    assign o_valid          = r_out_vld;
    assign o_cap_pos_x      = r_out_cap[0];
    assign o_cap_pos_y      = r_out_cap[1];
    assign o_cap_pos_z      = r_out_cap[2];
    assign o_qm_force_out_x = r_out_qfo[0];
    assign o_qm_force_out_y = r_out_qfo[1];
    assign o_qm_force_out_z = r_out_qfo[2];
    assign o_mm_force_out_x = r_out_mfo[0];
    assign o_mm_force_out_y = r_out_mfo[1];
    assign o_mm_force_out_z = r_out_mfo[2];
    assign o_fault          = r_out_fault;

    `LAPF_ASSERT(a_zero_gives_no_force, o_valid && (o_fault == FAULT_ZERO) |-> (o_mm_force_out_x == '0) && (o_qm_force_out_y == '0) && (o_mm_force_out_z == '0))
    `LAPF_ASSERT(a_held_item_blocks_input, r_out_vld && i_stall |-> o_stall)
    `LAPF_ASSERT_RST(a_reset_empties_pipe, !i_rst_n |=> !o_valid && !r_s12_vld && !r_s1_vld)

endmodule
`default_nettype wire

// ===== hdl/lapf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// Carries a sideband tag alongside; depends on nothing outside itself.
`default_nettype none
module lapf_div #(
    parameter int LANES = 1,
    parameter int NW    = 8,
    parameter int DW    = 8,
    parameter int QW    = 8,
    parameter int TW    = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [LANES-1:0][NW-1:0]   i_num,
    input  wire logic [DW-1:0]              i_den,
    input  wire logic [TW-1:0]              i_tag,
    output logic                            o_valid,
    output logic [LANES-1:0][QW-1:0]        o_quo,
    output logic [TW-1:0]                   o_tag
);
    localparam int CW = DW + QW;

    logic [LANES-1:0][CW-1:0] r_rem [QW];
    logic [LANES-1:0][QW-1:0] r_quo [QW];
    logic [DW-1:0]            r_den [QW];
    logic [TW-1:0]            r_tag [QW];
    logic [QW-1:0]            r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [LANES-1:0][CW-1:0] w_rem_in;
        logic [LANES-1:0][CW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] w_quo_in;
        logic [LANES-1:0][QW-1:0] n_quo;
        logic [DW-1:0]            w_den_in;
        logic [TW-1:0]            w_tag_in;
        logic [CW-1:0]            w_sub;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem_in[l] = CW'(i_num[l]);
                end
                w_quo_in = '0;
                w_den_in = i_den;
                w_tag_in = i_tag;
            end
        end else begin : g_next
            always_comb begin
                w_rem_in = r_rem[k-1];
                w_quo_in = r_quo[k-1];
                w_den_in = r_den[k-1];
                w_tag_in = r_tag[k-1];
            end
        end

        assign w_sub = CW'(w_den_in) << (QW - 1 - k);

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (w_rem_in[l] >= w_sub) begin
                    n_rem[l] = w_rem_in[l] - w_sub;
                    n_quo[l] = w_quo_in[l] | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_rem[l] = w_rem_in[l];
                    n_quo[l] = w_quo_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_den[k] <= w_den_in;
                r_tag[k] <= w_tag_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule
`default_nettype wire

// ===== hdl/lapf_sqrt.sv =====
// Pipelined integer square root (floor), one result bit per stage.
// Carries a sideband tag alongside; depends on nothing outside itself.
`default_nettype none
module lapf_sqrt #(
    parameter int NW = 62,
    parameter int TW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NW-1:0]     i_rad,
    input  wire logic [TW-1:0]     i_tag,
    output logic                   o_valid,
    output logic [NW/2-1:0]        o_root,
    output logic [TW-1:0]          o_tag
);
    localparam int SW = NW / 2;
    localparam int RW = NW + 1;

    logic [RW-1:0] r_rem  [SW];
    logic [RW-1:0] r_root [SW];
    logic [TW-1:0] r_tag  [SW];
    logic [SW-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SW-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [RW-1:0] w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [TW-1:0] w_tag_in;
        logic [RW-1:0] w_bit;
        logic [RW-1:0] w_trial;
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rem_in  = RW'(i_rad);
            assign w_root_in = '0;
            assign w_tag_in  = i_tag;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_tag_in  = r_tag[k-1];
        end

        assign w_bit   = RW'(1) << (NW - 2 - 2 * k);
        assign w_trial = w_root_in + w_bit;

        always_comb begin
            if (w_rem_in >= w_trial) begin
                n_rem  = w_rem_in - w_trial;
                n_root = (w_root_in >> 1) + w_bit;
            end else begin
                n_rem  = w_rem_in;
                n_root = w_root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_tag[k]  <= w_tag_in;
            end
        end
    end

    assign o_valid = r_vld[SW-1];
    assign o_root  = r_root[SW-1][SW-1:0];
    assign o_tag   = r_tag[SW-1];

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for link_atom_cap_force_projection_core.
// Drives link pairs with random idling, predicts cap and forces, checks each result item.
// Depends on lapf_pkg and the core RTL only.
`timescale 1ns / 100ps
module testbench;
    import lapf_pkg::*;

    typedef struct {
        logic [31:0] cap [3];
        logic [31:0] fqo [3];
        logic [31:0] fmo [3];
        t_fault      fault;
    } t_proj;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [31:0] in_f [12];
    logic o_valid;
    logic i_stall = 1'b0;
    logic [31:0] o_cap_pos_x, o_cap_pos_y, o_cap_pos_z;
    logic [31:0] o_qm_force_out_x, o_qm_force_out_y, o_qm_force_out_z;
    logic [31:0] o_mm_force_out_x, o_mm_force_out_y, o_mm_force_out_z;
    logic [1:0] o_fault;

    logic [20:0] bond_len = BOND_RESET;
    t_proj expected_q [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int zero_seen = 0, sat_seen = 0;

    initial for (int k = 0; k < 12; k++) in_f[k] = '0;

    always #5 i_clk = ~i_clk;

    link_atom_cap_force_projection_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_qm_pos_x(in_f[0]), .i_qm_pos_y(in_f[1]), .i_qm_pos_z(in_f[2]),
        .i_mm_pos_x(in_f[3]), .i_mm_pos_y(in_f[4]), .i_mm_pos_z(in_f[5]),
        .i_link_force_x(in_f[6]), .i_link_force_y(in_f[7]), .i_link_force_z(in_f[8]),
        .i_qm_force_x(in_f[9]), .i_qm_force_y(in_f[10]), .i_qm_force_z(in_f[11]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cap_pos_x(o_cap_pos_x), .o_cap_pos_y(o_cap_pos_y), .o_cap_pos_z(o_cap_pos_z),
        .o_qm_force_out_x(o_qm_force_out_x), .o_qm_force_out_y(o_qm_force_out_y),
        .o_qm_force_out_z(o_qm_force_out_z),
        .o_mm_force_out_x(o_mm_force_out_x), .o_mm_force_out_y(o_mm_force_out_y),
        .o_mm_force_out_z(o_mm_force_out_z),
        .o_fault(o_fault)
    );

    // round to nearest, ties away from zero; den positive
    function automatic logic signed [127:0] div_round(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root, lo, hi, mid;
        lo = 0;
        hi = 64'd4294967296;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        root = lo;
        return root;
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic hit);
        if (v > 128'sd2147483647) begin
            hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_proj project_link(input logic [31:0] f [12],
                                           input logic [20:0] bond);
        t_proj res;
        logic signed [127:0] pq [3], pm [3], fl [3], fq [3], r [3], a [3], u [3];
        logic signed [127:0] dot, dp, perp, fm, b, len;
        logic [63:0] mx, am, n2;
        int sh;
        logic hit;
        logic is_zero;
        hit = 1'b0;
        is_zero = 1'b1;
        mx = 0;
        n2 = 0;
        dot = 0;
        sh = 0;
        b = bond;
        for (int k = 0; k < 3; k++) begin
            pq[k] = $signed(f[k]);
            pm[k] = $signed(f[3+k]);
            fl[k] = $signed(f[6+k]);
            fq[k] = $signed(f[9+k]);
            r[k] = pm[k] - pq[k];
            if (r[k] != 0) is_zero = 1'b0;
            am = (r[k] < 0) ? -r[k] : r[k];
            if (am > mx) mx = am;
        end
        if (is_zero) begin
            for (int k = 0; k < 3; k++) begin
                res.cap[k] = f[k];
                res.fqo[k] = '0;
                res.fmo[k] = '0;
            end
            res.fault = FAULT_ZERO;
            return res;
        end
        while (sh < 3 && (mx >> sh) >= 64'd1073741824) sh++;
        for (int k = 0; k < 3; k++) begin
            am = ((r[k] < 0) ? -r[k] : r[k]) >> sh;
            a[k] = (r[k] < 0) ? -$signed({64'd0, am}) : $signed({64'd0, am});
            n2 += am * am;
        end
        len = int_sqrt(n2);
        if (len == 0) len = 1;
        for (int k = 0; k < 3; k++) begin
            u[k] = div_round(a[k] <<< UNIT_FRAC, len);
            dot += fl[k] * u[k];
        end
        dp = div_round(dot, 128'sd1 <<< UNIT_FRAC);
        for (int k = 0; k < 3; k++) begin
            perp = fl[k] - div_round(dp * u[k], 128'sd1 <<< UNIT_FRAC);
            fm = div_round(b * perp, len <<< sh);
            res.cap[k] = clamp32(pq[k] + div_round(b * a[k], len), hit);
            res.fmo[k] = clamp32(fm, hit);
            res.fqo[k] = clamp32(fq[k] + fl[k] - fm, hit);
        end
        res.fault = hit ? FAULT_SAT : FAULT_OK;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_stall === 1'b0 || i_stall === 1'bx) begin
            end
            if (o_valid && !i_stall) begin
                logic [31:0] got [10];
                t_proj exp_r;
                logic bad;
                got = '{o_cap_pos_x, o_cap_pos_y, o_cap_pos_z,
                        o_qm_force_out_x, o_qm_force_out_y, o_qm_force_out_z,
                        o_mm_force_out_x, o_mm_force_out_y, o_mm_force_out_z,
                        {30'd0, o_fault}};
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
                end else begin
                    exp_r = expected_q.pop_front();
                    bad = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        if (got[k] !== exp_r.cap[k]) bad = 1'b1;
                        if (got[3+k] !== exp_r.fqo[k]) bad = 1'b1;
                        if (got[6+k] !== exp_r.fmo[k]) bad = 1'b1;
                    end
                    if (got[9][1:0] !== exp_r.fault) bad = 1'b1;
                    if (exp_r.fault == FAULT_ZERO) zero_seen++;
                    if (exp_r.fault == FAULT_SAT) sat_seen++;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t: cap exp %h %h %h got %h %h %h", $realtime,
                                     exp_r.cap[0], exp_r.cap[1], exp_r.cap[2],
                                     got[0], got[1], got[2]);
                            $display("  fq_out exp %h %h %h got %h %h %h",
                                     exp_r.fqo[0], exp_r.fqo[1], exp_r.fqo[2],
                                     got[3], got[4], got[5]);
                            $display("  fm_out exp %h %h %h got %h %h %h fault exp %0d got %0d",
                                     exp_r.fmo[0], exp_r.fmo[1], exp_r.fmo[2],
                                     got[6], got[7], got[8], exp_r.fault, got[9][1:0]);
                        end
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic note_expected(input t_proj e);
        expected_q.insert(expected_q.size(), e);
    endtask

    // valid stays up after acceptance; the caller drives the next item or drops it
    task automatic send_pair(input logic [31:0] f [12]);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < 12; k++) in_f[k] <= f[k];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        note_expected(project_link(f, bond_len));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
    endtask

    task automatic write_bond(input logic [20:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {11'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        bond_len = v;
    endtask

    function automatic logic [31:0] rand_edge();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(2047) - 1024;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] f [12];
        for (int k = 0; k < 12; k++) f[k] = 0;
        send_pair(f);                       // zero separation
        f[3] = 32'd1 << 20; f[6] = 32'd5000; f[7] = 32'd3000; f[9] = 32'd77;
        send_pair(f);
        f[0] = 32'h8000_0000; f[3] = 32'h7FFF_FFFF;
        f[1] = 32'h7FFF_FFFF; f[4] = 32'h8000_0000;
        send_pair(f);                       // widest separation
        for (int k = 6; k < 12; k++) f[k] = 32'h7FFF_FFFF;
        send_pair(f);                       // force saturation
        for (int k = 6; k < 12; k++) f[k] = 32'h8000_0000;
        send_pair(f);
        for (int k = 0; k < 12; k++) f[k] = 32'hFFFF_FFFF;
        f[5] = 0;
        send_pair(f);                       // one-lsb separation
        for (int k = 0; k < 12; k++) f[k] = 32'h7FFF_FFFF;
        f[3] = 32'h7FFF_FFFE;
        send_pair(f);                       // cap near the top of range
        for (int n = 0; n < 12; n++) begin
            for (int k = 0; k < 12; k++) f[k] = rand_edge();
            send_pair(f);
        end
    endtask

    task automatic test_random(input int count);
        logic [31:0] f [12];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 12; k++) f[k] = $urandom;
            case ($urandom_range(3))
                0: for (int k = 0; k < 3; k++)   // realistic bond geometry
                       f[3+k] = f[k] + $urandom_range(400000) - 200000;
                1: for (int k = 0; k < 12; k++) f[k] = rand_edge();
                2: if ($urandom_range(3) == 0) for (int k = 0; k < 3; k++) f[3+k] = f[k];
                default: ;
            endcase
            if (n == count / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_q.size() != 0) @(posedge i_clk);
            end
            send_pair(f);
        end
    endtask

    task automatic test_bond_settings();
        drain_results();
        write_bond(21'd0);
        test_random(30);
        drain_results();
        write_bond(21'h1F_FFFF);
        test_random(30);
        drain_results();
        write_bond(21'd1 << 20);
        test_random(30);
        drain_results();
        write_bond(BOND_RESET);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 24; recv_stall_pct = 74;
        test_directed();
        test_random(150);
        send_idle_pct = 74; recv_stall_pct = 24;
        test_bond_settings();
        test_random(150);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(140);
        drain_results();
        $display("covered %0d link pairs over four bond lengths and three idling mixes",
                 results_seen);
        $display("zero separation results %0d, saturated results %0d", zero_seen, sat_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== link_atom_cap_force_projection_core.f =====
+incdir+hdl
hdl/lapf_pkg.sv
hdl/lapf_div.sv
hdl/lapf_sqrt.sv
hdl/link_atom_cap_force_projection_core.sv
dv/testbench.sv
